// ----- src/ohp_pkg.sv -----
// Shared types, constants and the arctangent table for the odometry and
// heading PID block. No dependencies; every other file imports this package.
package ohp_pkg;

    // Field widths.
    localparam int DT_W    = 16;
    localparam int SPEED_W = 16;
    localparam int RATE_W  = 24;
    localparam int POS_W   = 24;
    localparam int HEAD_W  = 16;
    localparam int Q14_W   = 16;
    localparam int DRIVE_W = 32;
    localparam int GAIN_W  = 16;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 3;

    // CORDIC step count, limited to the length of the arctangent table.
    localparam int CORDIC_STEPS = 16;
    localparam int TAB_LEN      = 24;
    localparam int CORDIC_N     = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
    localparam int STEP_W       = 5;
    localparam int CORD_XY_W    = 36;
    localparam int CORD_Z_W     = 34;
    localparam logic signed [CORD_XY_W-1:0] CORDIC_K = 36'sd652032874;

    // Bit-serial multiplier and divider sizes.
    localparam int MUL_A_W   = 48;
    localparam int MUL_B_W   = 16;
    localparam int MUL_CNT_W = 4;
    localparam int DIV_N_W   = 48;
    localparam int DIV_D_W   = 16;
    localparam int DIV_CNT_W = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GOAL_X = 3'd0,
        CFG_GOAL_Y = 3'd1,
        CFG_GAIN_P = 3'd2,
        CFG_GAIN_I = 3'd3,
        CFG_GAIN_D = 3'd4
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD,
        ST_ROT_FULL,
        ST_ROT_HALF,
        ST_MUL_VC,
        ST_MUL_X,
        ST_MUL_VS,
        ST_MUL_Y,
        ST_VEC,
        ST_MUL_E,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_DIV,
        ST_SUM,
        ST_OUT
    } ohp_state_t;

    typedef struct packed {
        logic start;
        logic b_signed;
    } mul_cmd_t;

    typedef struct packed {
        logic start;
        logic vectoring;
    } cordic_cmd_t;

    // Arctangent of 2^-i in units of 2^32 per turn.
    function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic [31:0] r;
        begin
            case (idx)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;
                5'd23: r = 32'h00000051;
                default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- src/ohp_mul.sv -----
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// Depends on ohp_pkg.
module ohp_mul (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ohp_pkg::mul_cmd_t                  cmd,
    input  logic signed [ohp_pkg::MUL_A_W-1:0] a,
    input  logic        [ohp_pkg::MUL_B_W-1:0] b,
    output logic                               done,
    output logic signed [ohp_pkg::MUL_A_W-1:0] product
);
    import ohp_pkg::*;

    logic signed [MUL_A_W-1:0] acc_reg;
    logic signed [MUL_A_W-1:0] a_reg;
    logic        [MUL_B_W-1:0] b_reg;
    logic [MUL_CNT_W-1:0]      cnt_reg;
    logic                      run_reg;
    logic                      sgn_reg;
    logic                      done_reg;
    logic                      last;

    assign last = (cnt_reg == MUL_CNT_W'(MUL_B_W - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The top bit of a signed multiplier carries negative weight.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
            sgn_reg <= cmd.b_signed;
        end else if (run_reg) begin
            if (b_reg[0]) begin
                if (last && sgn_reg) begin
                    acc_reg <= acc_reg - a_reg;
                end else begin
                    acc_reg <= acc_reg + a_reg;
                end
            end
            a_reg <= a_reg <<< 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- src/ohp_div.sv -----
// Restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Depends on ohp_pkg.
module ohp_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ohp_pkg::DIV_N_W-1:0] num,
    input  logic [ohp_pkg::DIV_D_W-1:0] den,
    output logic                        done,
    output logic [ohp_pkg::DIV_N_W-1:0] quot
);
    import ohp_pkg::*;

    logic [DIV_N_W-1:0]   q_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [DIV_D_W:0]     trial;
    logic                 fits;

    assign trial = {rem_reg, q_reg[DIV_N_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_N_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (run_reg) begin
            if (fits) begin
                rem_reg <= DIV_D_W'(trial - {1'b0, den_reg});
            end else begin
                rem_reg <= trial[DIV_D_W-1:0];
            end
            q_reg <= {q_reg[DIV_N_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ----- src/ohp_cordic.sv -----
// Iterative CORDIC, one micro-rotation per cycle, in rotation mode (cosine
// and sine in Q1.14) or vectoring mode (angle, 2^32 per turn). Depends on ohp_pkg.
module ohp_cordic (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ohp_pkg::cordic_cmd_t        cmd,
    input  logic signed [31:0]          angle,
    input  logic signed [24:0]          dx,
    input  logic signed [24:0]          dy,
    output logic                        done,
    output logic signed [ohp_pkg::Q14_W-1:0] cos_q,
    output logic signed [ohp_pkg::Q14_W-1:0] sin_q,
    output logic [31:0]                 angle_out
);
    import ohp_pkg::*;

    logic signed [CORD_XY_W-1:0] x_reg, y_reg;
    logic signed [CORD_Z_W-1:0]  z_reg;
    logic [STEP_W-1:0]           i_reg;
    logic                        run_reg, done_reg, vec_reg, neg_reg, zero_reg;

    logic signed [CORD_XY_W-1:0] xs, ys, x0, y0, xf, yf;
    logic signed [CORD_Z_W-1:0]  za, tab;
    logic                        plus;

    localparam logic signed [CORD_Z_W-1:0] QUARTER = 34'sh040000000;
    localparam logic signed [CORD_Z_W-1:0] HALF    = 34'sh080000000;

    assign xs   = x_reg >>> i_reg;
    assign ys   = y_reg >>> i_reg;
    assign tab  = {2'b00, atan_entry(i_reg)};
    assign plus = vec_reg ? (y_reg > 36'sd0) : (z_reg < 34'sd0);
    assign x0   = {{5{dx[24]}}, dx, 6'b0};
    assign y0   = {{5{dy[24]}}, dy, 6'b0};
    assign za   = {{2{angle[31]}}, angle};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                run_reg <= 1'b1;
                i_reg   <= '0;
            end else if (run_reg) begin
                i_reg <= i_reg + 1'b1;
                if (i_reg == STEP_W'(CORDIC_N - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            vec_reg <= cmd.vectoring;
            if (cmd.vectoring) begin
                neg_reg  <= 1'b0;
                zero_reg <= (dx == 25'sd0) && (dy == 25'sd0);
                if (dx < 25'sd0) begin
                    x_reg <= -x0;
                    y_reg <= -y0;
                    z_reg <= HALF;
                end else begin
                    x_reg <= x0;
                    y_reg <= y0;
                    z_reg <= '0;
                end
            end else begin
                zero_reg <= 1'b0;
                x_reg    <= CORDIC_K;
                y_reg    <= '0;
                // Fold the angle into the right half plane.
                if (za > QUARTER) begin
                    z_reg   <= za - HALF;
                    neg_reg <= 1'b1;
                end else if (za < -QUARTER) begin
                    z_reg   <= za + HALF;
                    neg_reg <= 1'b1;
                end else begin
                    z_reg   <= za;
                    neg_reg <= 1'b0;
                end
            end
        end else if (run_reg) begin
            if (plus) begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + tab;
            end else begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - tab;
            end
        end
    end

    function automatic logic signed [Q14_W-1:0] to_q14(input logic signed [CORD_XY_W-1:0] v);
        logic signed [CORD_XY_W-1:0] r;
        begin
            r = (v + 36'sd32768) >>> 16;
            if (r > 36'sd16384) begin
                return 16'sd16384;
            end else if (r < -36'sd16384) begin
                return -16'sd16384;
            end else begin
                return r[Q14_W-1:0];
            end
        end
    endfunction

    assign xf        = neg_reg ? -x_reg : x_reg;
    assign yf        = neg_reg ? -y_reg : y_reg;
    assign cos_q     = to_q14(xf);
    assign sin_q     = to_q14(yf);
    assign angle_out = zero_reg ? 32'd0 : z_reg[31:0];
    assign done      = done_reg;

endmodule

// ----- src/odometry_heading_pid_unit.sv -----
// Top level of the odometry and heading PID block: sequencer, state and
// configuration registers. Depends on ohp_pkg, ohp_mul, ohp_div, ohp_cordic.
//
// Each tick transfer on the s_ channel advances dead reckoning for a unicycle
// robot and returns one result transfer on the m_ channel. The heading is
// integrated first, then the position moves along the new heading by speed
// times interval, using CORDIC cosine and sine. The result carries the
// position, the heading, the yaw quaternion z and w (sin and cos of half the
// heading; x and y are always zero) and the PID drive that steers toward the
// goal point set through the configuration port. The block works on one tick
// at a time; products, rotations and the division run through a bit-serial
// multiplier (one bit of a 16-bit operand per cycle), an iterative CORDIC (one
// micro-rotation per cycle) and a restoring divider (one quotient bit per
// cycle). The divider is skipped when the interval is zero. The multiplier is
// used nine times per tick. The result sits in an output register, so the
// next tick is accepted while a result still waits to be taken. Configuration
// writes take effect at once and should only be made while the block is idle;
// writes to unused register indexes are ignored.
module odometry_heading_pid_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic        [ohp_pkg::DT_W-1:0]     s_tick_interval,
    input  logic signed [ohp_pkg::SPEED_W-1:0]  s_forward_speed,
    input  logic signed [ohp_pkg::RATE_W-1:0]   s_turn_rate,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [ohp_pkg::POS_W-1:0]    m_pos_x,
    output logic signed [ohp_pkg::POS_W-1:0]    m_pos_y,
    output logic signed [ohp_pkg::HEAD_W-1:0]   m_heading_out,
    output logic signed [ohp_pkg::Q14_W-1:0]    m_quat_z,
    output logic signed [ohp_pkg::Q14_W-1:0]    m_quat_w,
    output logic signed [ohp_pkg::DRIVE_W-1:0]  m_drive,
    input  logic                                cfg_we,
    input  logic        [ohp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [ohp_pkg::CFG_W-1:0]    cfg_data
);
    import ohp_pkg::*;

    // Sequencer.
    ohp_state_t state_reg, state_next;
    logic       entry_reg;

    // Configuration.
    logic signed [POS_W-1:0] goal_x_reg, goal_y_reg;
    logic [GAIN_W-1:0]       gain_p_reg, gain_i_reg, gain_d_reg;

    // Architectural state.
    logic signed [POS_W-1:0]   pos_x_reg, pos_y_reg;
    logic [HEAD_W-1:0]         heading_reg;
    logic signed [DRIVE_W-1:0] esum_reg;
    logic signed [HEAD_W-1:0]  last_err_reg;

    // Per-tick working registers.
    logic [DT_W-1:0]            dt_reg;
    logic signed [SPEED_W-1:0]  v_reg;
    logic signed [RATE_W-1:0]   w_reg;
    logic signed [Q14_W-1:0]    c_reg, s_reg, hc_reg, hs_reg;
    logic signed [31:0]         t_reg;
    logic signed [HEAD_W-1:0]   err_reg;
    logic signed [33:0]         p_reg;
    logic signed [39:0]         iv_reg;
    logic signed [48:0]         d_reg;
    logic [DIV_N_W-1:0]         dmag_reg;
    logic                       dneg_reg;
    logic signed [DRIVE_W-1:0]  drive_reg;

    // Output register.
    logic                       m_valid_reg;
    logic signed [POS_W-1:0]    out_x_reg, out_y_reg;
    logic signed [HEAD_W-1:0]   out_h_reg;
    logic signed [Q14_W-1:0]    out_z_reg, out_w_reg;
    logic signed [DRIVE_W-1:0]  out_d_reg;

    // Unit connections.
    mul_cmd_t                  mul_cmd;
    logic signed [MUL_A_W-1:0] mul_a, prod;
    logic [MUL_B_W-1:0]        mul_b;
    logic                      mul_done;
    cordic_cmd_t               cor_cmd;
    logic signed [31:0]        cor_angle;
    logic signed [24:0]        cor_dx, cor_dy;
    logic                      cor_done;
    logic signed [Q14_W-1:0]   cor_cos, cor_sin;
    logic [31:0]               cor_ang_out;
    logic                      div_start, div_done;
    logic [DIV_N_W-1:0]        div_quot;

    logic s_xfer, out_free, out_load;
    logic signed [HEAD_W-1:0] diff;
    logic [31:0]              bear_full;
    logic signed [47:0]       dnum;
    logic signed [47:0]       pos_delta_full;
    logic signed [24:0]       pos_sum;
    logic signed [40:0]       esum_sum;
    logic signed [51:0]       drive_sum;

    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign diff     = err_reg - last_err_reg;

    ohp_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mul_cmd),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (prod)
    );

    ohp_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cor_cmd),
        .angle     (cor_angle),
        .dx        (cor_dx),
        .dy        (cor_dy),
        .done      (cor_done),
        .cos_q     (cor_cos),
        .sin_q     (cor_sin),
        .angle_out (cor_ang_out)
    );

    ohp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (dmag_reg),
        .den     (dt_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_HEAD;
            ST_HEAD:     if (mul_done) state_next = ST_ROT_FULL;
            ST_ROT_FULL: if (cor_done) state_next = ST_ROT_HALF;
            ST_ROT_HALF: if (cor_done) state_next = ST_MUL_VC;
            ST_MUL_VC:   if (mul_done) state_next = ST_MUL_X;
            ST_MUL_X:    if (mul_done) state_next = ST_MUL_VS;
            ST_MUL_VS:   if (mul_done) state_next = ST_MUL_Y;
            ST_MUL_Y:    if (mul_done) state_next = ST_VEC;
            ST_VEC:      if (cor_done) state_next = ST_MUL_E;
            ST_MUL_E:    if (mul_done) state_next = ST_MUL_P;
            ST_MUL_P:    if (mul_done) state_next = ST_MUL_I;
            ST_MUL_I:    if (mul_done) state_next = ST_MUL_D;
            ST_MUL_D: begin
                if (mul_done) begin
                    state_next = (dt_reg == '0) ? ST_SUM : ST_DIV;
                end
            end
            ST_DIV:      if (div_done) state_next = ST_SUM;
            ST_SUM:      state_next = ST_OUT;
            ST_OUT:      if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake, unit launches and operands.
    always_comb begin
        s_ready          = (state_reg == ST_IDLE);
        out_load         = (state_reg == ST_OUT) && out_free;
        mul_cmd.start    = entry_reg && (state_reg inside {ST_HEAD, ST_MUL_VC, ST_MUL_X,
                           ST_MUL_VS, ST_MUL_Y, ST_MUL_E, ST_MUL_P, ST_MUL_I, ST_MUL_D});
        mul_cmd.b_signed = 1'b0;
        cor_cmd.start    = entry_reg && (state_reg inside {ST_ROT_FULL, ST_ROT_HALF, ST_VEC});
        cor_cmd.vectoring = (state_reg == ST_VEC);
        div_start        = entry_reg && (state_reg == ST_DIV);
        cor_angle        = (state_reg == ST_ROT_HALF) ? {heading_reg[15], heading_reg, 15'b0}
                                                      : {heading_reg, 16'b0};
        cor_dx           = {goal_x_reg[POS_W-1], goal_x_reg} - {pos_x_reg[POS_W-1], pos_x_reg};
        cor_dy           = {goal_y_reg[POS_W-1], goal_y_reg} - {pos_y_reg[POS_W-1], pos_y_reg};
        mul_a            = '0;
        mul_b            = '0;
        case (state_reg)
            ST_HEAD: begin
                mul_a = MUL_A_W'(w_reg);
                mul_b = dt_reg;
            end
            ST_MUL_VC: begin
                mul_a = MUL_A_W'(c_reg);
                mul_b = v_reg;
                mul_cmd.b_signed = 1'b1;
            end
            ST_MUL_VS: begin
                mul_a = MUL_A_W'(s_reg);
                mul_b = v_reg;
                mul_cmd.b_signed = 1'b1;
            end
            ST_MUL_X, ST_MUL_Y: begin
                mul_a = MUL_A_W'(t_reg);
                mul_b = dt_reg;
            end
            ST_MUL_E: begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = dt_reg;
            end
            ST_MUL_P: begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = gain_p_reg;
            end
            ST_MUL_I: begin
                mul_a = MUL_A_W'(esum_reg);
                mul_b = gain_i_reg;
            end
            ST_MUL_D: begin
                mul_a = MUL_A_W'(diff);
                mul_b = gain_d_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Datapath helpers for the captures below.
    assign bear_full      = cor_ang_out + 32'h0000_8000;
    assign dnum           = {prod[31:0], 16'b0};
    assign pos_delta_full = (prod + 48'sd33554432) >>> 26;
    assign pos_sum        = ((state_reg == ST_MUL_X) ? {pos_x_reg[POS_W-1], pos_x_reg}
                                                     : {pos_y_reg[POS_W-1], pos_y_reg})
                            + pos_delta_full[24:0];
    assign esum_sum       = {{9{esum_reg[DRIVE_W-1]}}, esum_reg} + 41'($signed(prod[47:8]));
    assign drive_sum      = 52'(p_reg) + 52'(iv_reg) + 52'(d_reg);

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [24:0] v);
        if (v > 25'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -25'sd8388608) begin
            return 24'sh800000;
        end else begin
            return v[POS_W-1:0];
        end
    endfunction

    function automatic logic signed [DRIVE_W-1:0] sat32(input logic signed [51:0] v);
        if (v > 52'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -52'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[DRIVE_W-1:0];
        end
    endfunction

    // Control, configuration and architectural state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            entry_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
            goal_x_reg   <= '0;
            goal_y_reg   <= '0;
            gain_p_reg   <= 16'd1229;
            gain_i_reg   <= 16'd4096;
            gain_d_reg   <= 16'd205;
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            heading_reg  <= '0;
            esum_reg     <= '0;
            last_err_reg <= '0;
        end else begin
            state_reg <= state_next;
            entry_reg <= (state_next != state_reg);
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index_t'(cfg_index))
                    CFG_GOAL_X: goal_x_reg <= cfg_data;
                    CFG_GOAL_Y: goal_y_reg <= cfg_data;
                    CFG_GAIN_P: gain_p_reg <= cfg_data[GAIN_W-1:0];
                    CFG_GAIN_I: gain_i_reg <= cfg_data[GAIN_W-1:0];
                    CFG_GAIN_D: gain_d_reg <= cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_HEAD && mul_done) begin
                heading_reg <= heading_reg + prod[31:16];
            end
            if (state_reg == ST_MUL_X && mul_done) begin
                pos_x_reg <= sat_pos(pos_sum);
            end
            if (state_reg == ST_MUL_Y && mul_done) begin
                pos_y_reg <= sat_pos(pos_sum);
            end
            if (state_reg == ST_MUL_E && mul_done) begin
                esum_reg <= sat32(52'(esum_sum));
            end
            if (state_reg == ST_SUM) begin
                last_err_reg <= err_reg;
            end
        end
    end

    // Per-tick working registers and the output register.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            dt_reg <= s_tick_interval;
            v_reg  <= s_forward_speed;
            w_reg  <= s_turn_rate;
        end
        if (state_reg == ST_ROT_FULL && cor_done) begin
            c_reg <= cor_cos;
            s_reg <= cor_sin;
        end
        if (state_reg == ST_ROT_HALF && cor_done) begin
            hc_reg <= cor_cos;
            hs_reg <= cor_sin;
        end
        if ((state_reg == ST_MUL_VC || state_reg == ST_MUL_VS) && mul_done) begin
            t_reg <= prod[31:0];
        end
        if (state_reg == ST_VEC && cor_done) begin
            err_reg <= bear_full[31:16] - heading_reg;
        end
        if (state_reg == ST_MUL_P && mul_done) begin
            p_reg <= prod[33:0];
        end
        if (state_reg == ST_MUL_I && mul_done) begin
            iv_reg <= prod[47:8];
        end
        if (state_reg == ST_MUL_D && mul_done) begin
            // The derivative is zero unless the divider replaces it.
            d_reg    <= '0;
            dneg_reg <= dnum[47];
            dmag_reg <= dnum[47] ? DIV_N_W'(-dnum) : DIV_N_W'(dnum);
        end
        if (state_reg == ST_DIV && div_done) begin
            d_reg <= dneg_reg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
        end
        if (state_reg == ST_SUM) begin
            drive_reg <= sat32(drive_sum);
        end
        if (out_load) begin
            out_x_reg <= pos_x_reg;
            out_y_reg <= pos_y_reg;
            out_h_reg <= heading_reg;
            out_z_reg <= hs_reg;
            out_w_reg <= hc_reg;
            out_d_reg <= drive_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pos_x       = out_x_reg;
    assign m_pos_y       = out_y_reg;
    assign m_heading_out = out_h_reg;
    assign m_quat_z      = out_z_reg;
    assign m_quat_w      = out_w_reg;
    assign m_drive       = out_d_reg;

endmodule

// ----- src/ohp_checker.sv -----
// Port-level checks for the odometry and heading PID block, bound to the top
// level. Depends on ohp_pkg and odometry_heading_pid_unit.
module ohp_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic        [ohp_pkg::DT_W-1:0]     s_tick_interval,
    input logic signed [ohp_pkg::SPEED_W-1:0]  s_forward_speed,
    input logic signed [ohp_pkg::RATE_W-1:0]   s_turn_rate,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [ohp_pkg::POS_W-1:0]    m_pos_x,
    input logic signed [ohp_pkg::POS_W-1:0]    m_pos_y,
    input logic signed [ohp_pkg::HEAD_W-1:0]   m_heading_out,
    input logic signed [ohp_pkg::Q14_W-1:0]    m_quat_z,
    input logic signed [ohp_pkg::Q14_W-1:0]    m_quat_w,
    input logic signed [ohp_pkg::DRIVE_W-1:0]  m_drive,
    input logic                                cfg_we,
    input logic        [ohp_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic        [ohp_pkg::CFG_W-1:0]    cfg_data
);
    import ohp_pkg::*;

    // No result is offered right after reset.
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // One tick at a time: after a transfer in, the input stays closed.
    a_one_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second tick accepted while one is in flight");

    // A stalled result is not withdrawn.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive) && $stable(m_pos_x))
        else $error("stalled result changed");

    // Quaternion terms stay within plus and minus one in Q1.14.
    a_quat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_quat_z >= -16'sd16384) && (m_quat_z <= 16'sd16384)
                 && (m_quat_w >= -16'sd16384) && (m_quat_w <= 16'sd16384))
        else $error("quaternion term out of range");

endmodule

bind odometry_heading_pid_unit ohp_checker u_ohp_checker (.*);

// ----- dv/odometry_heading_pid_unit_tb.sv -----
// Self-checking testbench for odometry_heading_pid_unit: directed and random
// tick transfers checked against an in-bench predictor. Depends on ohp_pkg and the RTL.
`timescale 1ns / 100ps

module odometry_heading_pid_unit_tb;
    import ohp_pkg::*;

    localparam int SETTLE_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD = 3000;
    localparam int RANDOM_PER_PHASE = 340;
    // An index past the register list; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

    typedef struct {
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [HEAD_W-1:0]  heading;
        logic signed [Q14_W-1:0]   quat_z;
        logic signed [Q14_W-1:0]   quat_w;
        logic signed [DRIVE_W-1:0] drive;
    } odom_result_t;

    typedef struct {
        logic [DT_W-1:0]           dt;
        logic signed [SPEED_W-1:0] speed;
        logic signed [RATE_W-1:0]  rate;
        bit                        at_rest;  // result is all zero but the quaternion
    } tick_row_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic        [DT_W-1:0]       s_tick_interval;
    logic signed [SPEED_W-1:0]    s_forward_speed;
    logic signed [RATE_W-1:0]     s_turn_rate;
    logic                         m_valid;
    logic                         m_ready;
    logic signed [POS_W-1:0]      m_pos_x;
    logic signed [POS_W-1:0]      m_pos_y;
    logic signed [HEAD_W-1:0]     m_heading_out;
    logic signed [Q14_W-1:0]      m_quat_z;
    logic signed [Q14_W-1:0]      m_quat_w;
    logic signed [DRIVE_W-1:0]    m_drive;
    logic                         cfg_we;
    logic        [CFG_IDX_W-1:0]  cfg_index;
    logic        [CFG_W-1:0]      cfg_data;

    odometry_heading_pid_unit u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_tick_interval (s_tick_interval),
        .s_forward_speed (s_forward_speed),
        .s_turn_rate     (s_turn_rate),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pos_x         (m_pos_x),
        .m_pos_y         (m_pos_y),
        .m_heading_out   (m_heading_out),
        .m_quat_z        (m_quat_z),
        .m_quat_w        (m_quat_w),
        .m_drive         (m_drive),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // Predictor state: a private copy of the block's registers.
    logic signed [POS_W-1:0] goal_x_q, goal_y_q;
    logic [GAIN_W-1:0]       kp_q, ki_q, kd_q;
    logic signed [POS_W-1:0] est_x, est_y;
    logic [HEAD_W-1:0]       est_heading;
    longint                  err_integral;
    longint                  prev_err;

    odom_result_t pending_results[$];
    int  fail_count;
    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  hold_request;
    int  hold_left;
    int  quiet_cycles;

    // Arctangent of 2^-i, 2^32 units per turn.
    const logic [31:0] ATAN_LUT [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // The first 16 rows probe the field extremes and the zero-interval case;
    // the last rows are full-speed straight runs that push y toward saturation.
    const tick_row_t DIRECTED_TICKS [0:21] = '{
        '{16'd0,     16'sd0,      24'sd0,        1'b1},
        '{16'd0,     16'sd32767,  24'sd8388607,  1'b1},
        '{16'd0,     -16'sd32768, -24'sd8388608, 1'b0},
        '{16'd65535, 16'sd32767,  24'sd8388607,  1'b0},
        '{16'd65535, -16'sd32768, -24'sd8388608, 1'b0},
        '{16'd1,     16'sd1,      24'sd1,        1'b0},
        '{16'd1,     -16'sd1,     -24'sd1,       1'b0},
        '{16'd32768, 16'sd4096,   24'sd65536,    1'b0},
        '{16'd100,   16'sd0,      24'sd16384,    1'b0},
        '{16'd0,     16'sd4096,   24'sd0,        1'b0},
        '{16'd65535, 16'sd32767,  24'sd0,        1'b0},
        '{16'd65535, -16'sd32768, 24'sd0,        1'b0},
        '{16'd21845, 16'sd12345,  24'sd3000000,  1'b0},
        '{16'd65535, 16'sd32767,  -24'sd40000,   1'b0},
        '{16'd0,     16'sd100,    24'sd100,      1'b0},
        '{16'd4096,  16'sd32767,  24'sd65535,    1'b0},
        '{16'd65535, 16'sd32767,  24'sd0,        1'b0},
        '{16'd65535, 16'sd32767,  24'sd0,        1'b0},
        '{16'd65535, 16'sd32767,  24'sd0,        1'b0},
        '{16'd65535, 16'sd32767,  24'sd0,        1'b0},
        '{16'd65535, 16'sd32767,  24'sd0,        1'b0},
        '{16'd65535, 16'sd32767,  24'sd0,        1'b0}
    };

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Rotation-mode CORDIC: cosine and sine of an angle, rounded to Q1.14.
    function automatic void sin_cos_q14(input logic [31:0] angle,
                                        output longint cos_q, output longint sin_q);
        longint z, x, y, nx;
        bit     flip;
        z = (angle >= 32'h80000000) ? longint'(angle) - 64'sh100000000 : longint'(angle);
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > 64'sh40000000) begin
            z -= 64'sh80000000;
            flip = 1;
        end else if (z < -64'sh40000000) begin
            z += 64'sh80000000;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_N; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= longint'(ATAN_LUT[i]);
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += longint'(ATAN_LUT[i]);
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cos_q = clip((x + 32768) >>> 16, -16384, 16384);
        sin_q = clip((y + 32768) >>> 16, -16384, 16384);
    endfunction

    // Vectoring-mode CORDIC: bearing of (dx, dy), 2^32 units per turn.
    function automatic logic [31:0] bearing_of(input longint dy, input longint dx);
        longint      x, y, nx;
        logic [31:0] z;
        x = dx * 64;
        y = dy * 64;
        z = 32'h0;
        if (x == 0 && y == 0) return 32'h0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < CORDIC_N; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += ATAN_LUT[i];
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= ATAN_LUT[i];
            end
            x = nx;
        end
        return z;
    endfunction

    // Advances the predictor by one tick and queues the result it implies.
    task automatic predict_tick(input logic [DT_W-1:0] dt_in,
                                input logic signed [SPEED_W-1:0] speed_in,
                                input logic signed [RATE_W-1:0] rate_in,
                                input bit at_rest);
        longint       dt, v, c, s, hc, hs, err, diff, p_term, i_term, d_term, total;
        logic [31:0]  bear32;
        logic [15:0]  bear, err16, diff16;
        odom_result_t r;
        dt = longint'(dt_in);
        v = longint'(speed_in);
        est_heading = est_heading + 16'((longint'(rate_in) * dt) >>> 16);
        sin_cos_q14({est_heading, 16'h0}, c, s);
        sin_cos_q14({est_heading[15], est_heading, 15'h0}, hc, hs);
        est_x = POS_W'(clip(longint'(est_x) + ((v * c * dt + (64'sd1 <<< 25)) >>> 26),
                            -8388608, 8388607));
        est_y = POS_W'(clip(longint'(est_y) + ((v * s * dt + (64'sd1 <<< 25)) >>> 26),
                            -8388608, 8388607));
        bear32 = bearing_of(longint'(goal_y_q) - longint'(est_y),
                            longint'(goal_x_q) - longint'(est_x));
        bear = 16'((bear32 + 32'h8000) >> 16);
        err16 = bear - est_heading;
        err = longint'($signed(err16));
        err_integral = clip(err_integral + ((err * dt) >>> 8), -64'sd2147483648, 64'sd2147483647);
        p_term = longint'(kp_q) * err;
        i_term = (longint'(ki_q) * err_integral) >>> 8;
        d_term = 0;
        if (dt != 0) begin
            diff16 = err16 - 16'(prev_err);
            diff = longint'($signed(diff16));
            d_term = (longint'(kd_q) * diff * 65536) / dt;
        end
        total = clip(p_term + i_term + d_term, -64'sd2147483648, 64'sd2147483647);
        prev_err = err;
        r.pos_x = est_x;
        r.pos_y = est_y;
        r.heading = est_heading;
        r.quat_z = Q14_W'(hs);
        r.quat_w = Q14_W'(hc);
        r.drive = DRIVE_W'(total);
        // Rows typed in as a result at rest override what the predictor says.
        if (at_rest) begin
            r.pos_x = '0;
            r.pos_y = '0;
            r.heading = '0;
            r.drive = '0;
        end
        pending_results.push_back(r);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Writes every register at the configuration port, plus one write to a
    // spare index that the block must drop.
    task automatic program_regs(input logic [CFG_W-1:0] gx, input logic [CFG_W-1:0] gy,
                                input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                                input logic [GAIN_W-1:0] kd);
        logic [CFG_IDX_W-1:0] idx [0:5];
        logic [CFG_W-1:0]     val [0:5];
        idx = '{CFG_GOAL_X, CFG_GOAL_Y, CFG_GAIN_P, CFG_GAIN_I, CFG_GAIN_D, CFG_SPARE_IDX};
        val = '{gx, gy, {8'h0, kp}, {8'h0, ki}, {8'h0, kd}, 24'hA5A5A5};
        for (int i = 0; i < 6; i++) begin
            @(posedge aclk);
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
        goal_x_q = gx;
        goal_y_q = gy;
        kp_q = kp;
        ki_q = ki;
        kd_q = kd;
    endtask

    // Offers one tick and holds it until the block takes it. A random gap
    // before the tick drops valid first; otherwise valid stays high.
    task automatic send_tick(input logic [DT_W-1:0] dt, input logic signed [SPEED_W-1:0] v,
                             input logic signed [RATE_W-1:0] w, input bit at_rest);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_tick_interval <= dt;
        s_forward_speed <= v;
        s_turn_rate <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_tick(dt, v, w, at_rest);
    endtask

    // Random tick: mostly moderate intervals, with the extremes of every
    // field and the zero interval mixed in.
    task automatic send_random_tick();
        logic [DT_W-1:0]           dt;
        logic signed [SPEED_W-1:0] v;
        logic signed [RATE_W-1:0]  w;
        int                        pick;
        pick = $urandom_range(99);
        if (pick < 8) dt = '0;
        else if (pick < 14) dt = 16'hFFFF;
        else if (pick < 45) dt = DT_W'($urandom);
        else dt = DT_W'($urandom_range(4096));
        pick = $urandom_range(99);
        if (pick < 10) v = 16'sh7FFF;
        else if (pick < 20) v = -16'sh8000;
        else v = SPEED_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 8) w = 24'sh7FFFFF;
        else if (pick < 16) w = -24'sh800000;
        else if (pick < 60) w = RATE_W'($urandom);
        else w = RATE_W'($signed($urandom_range(200000)) - 100000);
        send_tick(dt, v, w, 1'b0);
    endtask

    // Stops offering ticks at the edge of the last transfer and lets every
    // queued result come back.
    task automatic drain();
        s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: checks each transfer against the oldest prediction and
    // chooses the next ready value, including the long hold-off.
    always @(posedge aclk) begin
        odom_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t ns: result transfer with no prediction waiting", $time);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("pos_x", want.pos_x, m_pos_x);
                    check_field("pos_y", want.pos_y, m_pos_y);
                    check_field("heading_out", want.heading, m_heading_out);
                    check_field("quat_z", want.quat_z, m_quat_z);
                    check_field("quat_w", want.quat_w, m_quat_w);
                    check_field("drive", want.drive, m_drive);
                end
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left <= LONG_HOLD;
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: too long with no transfer on either channel ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_tick_interval = '0;
        s_forward_speed = '0;
        s_turn_rate = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_GOAL_X;
        cfg_data = '0;
        fail_count = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_request = 1'b0;
        quiet_cycles = 0;
        // Register reset values, and zero for the rest of the state.
        goal_x_q = '0;
        goal_y_q = '0;
        kp_q = 16'd1229;
        ki_q = 16'd4096;
        kd_q = 16'd205;
        est_x = '0;
        est_y = '0;
        est_heading = '0;
        err_integral = 0;
        prev_err = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, with the reset configuration.
        foreach (DIRECTED_TICKS[i])
            send_tick(DIRECTED_TICKS[i].dt, DIRECTED_TICKS[i].speed,
                      DIRECTED_TICKS[i].rate, DIRECTED_TICKS[i].at_rest);
        drain();

        // Phase one: far corner goal, all gains at maximum, so the integral
        // and the drive saturate. The receiver idles most, and holds off once
        // long enough for the block to stall its input.
        program_regs(24'h7FFFFF, 24'h800000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        tx_idle_pct = 20;
        rx_idle_pct = 48;
        for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            if (i == 40) hold_request = 1'b1;
            send_random_tick();
        end
        drain();

        // Phase two: opposite goal, zero gains; the sender idles most.
        program_regs(24'h800000, 24'h7FFFFF, 16'h0000, 16'h0000, 16'h0000);
        tx_idle_pct = 48;
        rx_idle_pct = 20;
        for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random_tick();
        drain();

        // Phase three: random goal and gains, back to back on both sides.
        program_regs(CFG_W'($urandom), CFG_W'($urandom), GAIN_W'($urandom),
                     GAIN_W'($urandom), GAIN_W'($urandom));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random_tick();
        drain();

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // A prediction left over at the end is caught by drain: the wait never
    // finishes and the watchdog fails the run.

endmodule
